### rtl/lpbd_pkg.sv
// Shared constants for the length-prefixed block deframer.
// This file holds the character codes, the event and error codes, the field widths and the reset values.
// It has no dependencies.
`timescale 1ns / 1ps

package lpbd_pkg;

    // Field widths of the streams.
    localparam int BYTE_W     = 8;
    localparam int EVENT_W    = 3;
    localparam int ERR_W      = 3;
    localparam int BLK_W      = 16;
    localparam int PKT_W      = 32;
    localparam int M_TDATA_W  = 32;

    // Parameter defaults.
    localparam int HEADER_BUFFER_BYTES_DEF = 20;
    localparam int COUNT_WIDTH_DEF         = 32;

    // Reset value of the packet size limit.
    localparam logic [PKT_W-1:0] MAX_PACKET_RESET = 32'd134217728;

    // Character codes.
    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_STAR  = 8'h2A;
    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

    // Event codes carried on m_tuser.
    localparam logic [EVENT_W-1:0] EV_NONE  = 3'd0;
    localparam logic [EVENT_W-1:0] EV_BODY  = 3'd1;
    localparam logic [EVENT_W-1:0] EV_LAST  = 3'd2;
    localparam logic [EVENT_W-1:0] EV_EMPTY = 3'd3;
    localparam logic [EVENT_W-1:0] EV_END   = 3'd4;
    localparam logic [EVENT_W-1:0] EV_ERROR = 3'd5;

    // Error codes.
    localparam logic [ERR_W-1:0] ERR_NONE   = 3'd0;
    localparam logic [ERR_W-1:0] ERR_HEADER = 3'd1;
    localparam logic [ERR_W-1:0] ERR_LONG   = 3'd2;
    localparam logic [ERR_W-1:0] ERR_TERM   = 3'd3;
    localparam logic [ERR_W-1:0] ERR_LARGE  = 3'd4;
    localparam logic [ERR_W-1:0] ERR_OTHER  = 3'd5;

endpackage

### rtl/length_prefixed_block_deframer.sv
// Top level of the length-prefixed block deframer.
// The module takes one byte per beat and gives one event beat back for each byte.
// It depends on lpbd_pkg.
// Path: the byte is caught in an input register, and its result is then loaded into the result register.
// Throughput: one byte per cycle unless m_tready stalls the output.
//   The parse state is updated in one short combinational pass.
// Reset: aresetn is synchronous and active low. It empties both registers, returns the parser
//   to packet start and sets max_packet_bytes to 134217728.
`timescale 1ns / 1ps

module length_prefixed_block_deframer #(
    parameter int HEADER_BUFFER_BYTES = lpbd_pkg::HEADER_BUFFER_BYTES_DEF,
    parameter int COUNT_WIDTH         = lpbd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration write channel: max_packet_bytes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lpbd_pkg::PKT_W-1:0]       cfg_data,
    // Input stream. s_tdata holds in_byte[7:0].
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [lpbd_pkg::BYTE_W-1:0]      s_tdata,
    // Result stream.
    // m_tdata, from the lowest bit up: data[7:0], error_code[10:8], block_count[26:11], zero pad.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [lpbd_pkg::M_TDATA_W-1:0]   m_tdata,
    // m_tuser holds event_res[2:0].
    output logic [lpbd_pkg::EVENT_W-1:0]     m_tuser
);

    localparam int HL_W = $clog2(HEADER_BUFFER_BYTES);
    localparam logic [HL_W:0] HL_LIMIT = (HL_W+1)'(HEADER_BUFFER_BYTES - 1);
    localparam int PAD_W = lpbd_pkg::M_TDATA_W - lpbd_pkg::BYTE_W - lpbd_pkg::ERR_W
                           - lpbd_pkg::BLK_W;

    typedef enum logic [2:0] {
        PH_START,
        PH_HEADER,
        PH_BODY,
        PH_TERM,
        PH_TERM_CR,
        PH_BLOCK,
        PH_BLOCK_CR
    } phase_t;

    // Registers
    phase_t                          phase_reg, phase_next;
    logic [HL_W-1:0]                 hdr_len_reg, hdr_len_next;
    logic                            digits_done_reg, digits_done_next;
    logic [COUNT_WIDTH-1:0]          body_rem_reg, body_rem_next;
    logic [lpbd_pkg::PKT_W-1:0]      pkt_bytes_reg, pkt_bytes_next;
    logic [lpbd_pkg::BLK_W-1:0]      blocks_reg, blocks_next;
    logic [lpbd_pkg::PKT_W-1:0]      max_pkt_reg;

    logic                            in_valid_reg;
    logic [lpbd_pkg::BYTE_W-1:0]     in_byte_reg;

    logic                            out_valid_reg;
    logic [lpbd_pkg::EVENT_W-1:0]    ev_reg, ev_next;
    logic [lpbd_pkg::BYTE_W-1:0]     data_reg, data_next;
    logic [lpbd_pkg::ERR_W-1:0]      err_reg, err_next;
    logic [lpbd_pkg::BLK_W-1:0]      cnt_reg, cnt_next;

    // Helper values
    logic                            advance;
    logic                            is_digit;
    logic [3:0]                      digit;
    logic [HL_W:0]                   hdr_len_inc;
    logic [COUNT_WIDTH+3:0]          len_prod;
    logic [COUNT_WIDTH-1:0]          len_sat;
    logic [lpbd_pkg::PKT_W-1:0]      pkt_inc;
    logic [lpbd_pkg::BLK_W-1:0]      blocks_inc;
    logic [lpbd_pkg::BYTE_W-1:0]     byte_off;

    // Handshake: the output register frees when it is empty or being taken.
    // Nothing is taken while reset is held.
    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = aresetn && (!in_valid_reg || advance);
    assign cfg_ready = aresetn;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = ev_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, cnt_reg, err_reg, data_reg};

    // Byte classification and arithmetic helpers
    assign is_digit    = (in_byte_reg >= lpbd_pkg::CHAR_ZERO) &&
                         (in_byte_reg <= lpbd_pkg::CHAR_NINE);
    assign byte_off    = in_byte_reg - lpbd_pkg::CHAR_ZERO;
    assign digit       = byte_off[3:0];
    assign hdr_len_inc = {1'b0, hdr_len_reg} + (HL_W+1)'(1);
    assign len_prod    = ({4'b0, body_rem_reg} << 3) + ({4'b0, body_rem_reg} << 1)
                         + (COUNT_WIDTH+4)'(digit);
    assign len_sat     = (len_prod[COUNT_WIDTH+3:COUNT_WIDTH] != 4'd0) ?
                         {COUNT_WIDTH{1'b1}} : len_prod[COUNT_WIDTH-1:0];
    assign pkt_inc     = (pkt_bytes_reg != {lpbd_pkg::PKT_W{1'b1}}) ?
                         pkt_bytes_reg + lpbd_pkg::PKT_W'(1) : pkt_bytes_reg;
    assign blocks_inc  = (blocks_reg != {lpbd_pkg::BLK_W{1'b1}}) ?
                         blocks_reg + lpbd_pkg::BLK_W'(1) : blocks_reg;

    // Parse step for the byte in the input register
    always_comb begin
        phase_next       = phase_reg;
        hdr_len_next     = hdr_len_reg;
        digits_done_next = digits_done_reg;
        body_rem_next    = body_rem_reg;
        pkt_bytes_next   = pkt_inc;
        blocks_next      = blocks_reg;
        ev_next          = lpbd_pkg::EV_NONE;
        data_next        = '0;
        err_next         = lpbd_pkg::ERR_NONE;
        cnt_next         = '0;

        unique case (phase_reg)
            PH_START: begin
                if (in_byte_reg == lpbd_pkg::CHAR_LF || in_byte_reg == lpbd_pkg::CHAR_CR) begin
                    ev_next = lpbd_pkg::EV_NONE;
                end else if (in_byte_reg == lpbd_pkg::CHAR_STAR) begin
                    ev_next  = lpbd_pkg::EV_ERROR;
                    err_next = lpbd_pkg::ERR_OTHER;
                end else if (!is_digit) begin
                    ev_next  = lpbd_pkg::EV_ERROR;
                    err_next = lpbd_pkg::ERR_HEADER;
                end else begin
                    phase_next       = PH_HEADER;
                    hdr_len_next     = HL_W'(1);
                    digits_done_next = 1'b0;
                    body_rem_next    = COUNT_WIDTH'(digit);
                end
            end
            PH_BLOCK, PH_BLOCK_CR: begin
                if (in_byte_reg == lpbd_pkg::CHAR_LF) begin
                    // Empty line: the packet is complete.
                    ev_next  = lpbd_pkg::EV_END;
                    cnt_next = blocks_reg;
                end else if (phase_reg == PH_BLOCK && in_byte_reg == lpbd_pkg::CHAR_CR) begin
                    phase_next = PH_BLOCK_CR;
                end else if (phase_reg == PH_BLOCK_CR || !is_digit) begin
                    ev_next  = lpbd_pkg::EV_ERROR;
                    err_next = lpbd_pkg::ERR_HEADER;
                end else begin
                    phase_next       = PH_HEADER;
                    hdr_len_next     = HL_W'(1);
                    digits_done_next = 1'b0;
                    body_rem_next    = COUNT_WIDTH'(digit);
                end
            end
            PH_HEADER: begin
                if (in_byte_reg == lpbd_pkg::CHAR_LF) begin
                    hdr_len_next     = '0;
                    digits_done_next = 1'b0;
                    if (body_rem_reg == '0) begin
                        blocks_next = blocks_inc;
                        phase_next  = PH_TERM;
                        ev_next     = lpbd_pkg::EV_EMPTY;
                    end else begin
                        phase_next = PH_BODY;
                    end
                end else if (hdr_len_inc >= HL_LIMIT) begin
                    ev_next  = lpbd_pkg::EV_ERROR;
                    err_next = lpbd_pkg::ERR_LONG;
                end else begin
                    hdr_len_next = hdr_len_inc[HL_W-1:0];
                    // The length is the run of leading digits only.
                    if (!digits_done_reg) begin
                        if (is_digit) begin
                            body_rem_next = len_sat;
                        end else begin
                            digits_done_next = 1'b1;
                        end
                    end
                end
            end
            PH_BODY: begin
                data_next = in_byte_reg;
                if (body_rem_reg <= COUNT_WIDTH'(1)) begin
                    body_rem_next = '0;
                    blocks_next   = blocks_inc;
                    phase_next    = PH_TERM;
                    ev_next       = lpbd_pkg::EV_LAST;
                end else begin
                    body_rem_next = body_rem_reg - COUNT_WIDTH'(1);
                    ev_next       = lpbd_pkg::EV_BODY;
                end
            end
            PH_TERM, PH_TERM_CR: begin
                if (in_byte_reg == lpbd_pkg::CHAR_LF) begin
                    // The size check is made at the end of each block terminator.
                    if (pkt_inc > max_pkt_reg) begin
                        ev_next  = lpbd_pkg::EV_ERROR;
                        err_next = lpbd_pkg::ERR_LARGE;
                    end else begin
                        phase_next = PH_BLOCK;
                    end
                end else if (phase_reg == PH_TERM && in_byte_reg == lpbd_pkg::CHAR_CR) begin
                    phase_next = PH_TERM_CR;
                end else begin
                    ev_next  = lpbd_pkg::EV_ERROR;
                    err_next = lpbd_pkg::ERR_TERM;
                end
            end
            default: begin
                ev_next = lpbd_pkg::EV_NONE;
            end
        endcase

        // Packet end, any error and an unused phase code all return to packet start.
        if (ev_next == lpbd_pkg::EV_END || ev_next == lpbd_pkg::EV_ERROR ||
            phase_reg == PH_START && ev_next == lpbd_pkg::EV_NONE &&
            phase_next == PH_START ||
            !(phase_reg == PH_START || phase_reg == PH_HEADER || phase_reg == PH_BODY ||
              phase_reg == PH_TERM || phase_reg == PH_TERM_CR || phase_reg == PH_BLOCK ||
              phase_reg == PH_BLOCK_CR)) begin
            if (ev_next == lpbd_pkg::EV_END || ev_next == lpbd_pkg::EV_ERROR ||
                phase_reg != PH_START) begin
                phase_next       = PH_START;
                hdr_len_next     = '0;
                digits_done_next = 1'b0;
                body_rem_next    = '0;
                pkt_bytes_next   = '0;
                blocks_next      = '0;
            end
        end
    end

    // Input register, parse state, result register and configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            phase_reg       <= PH_START;
            hdr_len_reg     <= '0;
            digits_done_reg <= 1'b0;
            body_rem_reg    <= '0;
            pkt_bytes_reg   <= '0;
            blocks_reg      <= '0;
            max_pkt_reg     <= lpbd_pkg::MAX_PACKET_RESET;
        end else begin
            if (cfg_valid) begin
                max_pkt_reg <= cfg_data;
            end

            if (s_tvalid && s_tready) begin
                in_byte_reg <= s_tdata;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end

            if (advance) begin
                out_valid_reg <= in_valid_reg;
                if (in_valid_reg) begin
                    phase_reg       <= phase_next;
                    hdr_len_reg     <= hdr_len_next;
                    digits_done_reg <= digits_done_next;
                    body_rem_reg    <= body_rem_next;
                    pkt_bytes_reg   <= pkt_bytes_next;
                    blocks_reg      <= blocks_next;
                    ev_reg          <= ev_next;
                    data_reg        <= data_next;
                    err_reg         <= err_next;
                    cnt_reg         <= cnt_next;
                end
            end
        end
    end

endmodule
